// ===== hdl/mm3_pkg.sv =====
// Shared types and codes for the 3x3 fixed-point matrix multiplier.
package mm3_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_A   = 2'd0,
    OP_LOAD_B   = 2'd1,
    OP_MULTIPLY = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
  } cmd_t;

  typedef struct packed {
    logic [3:0]         product_index;
    logic signed [31:0] product_value;
    logic               last_result;
  } prod_t;

  // Control that travels with each dot product down the chain.
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [3:0] index;
  } tag_t;

endpackage

// ===== hdl/mm3_cell.sv =====
// One chain cell: holds column k of A and row k of B, adds its product term.
module mm3_cell #(
  parameter int DIM   = 3,
  parameter int K     = 0,
  parameter int SUM_W = 66,
  localparam int RC_W = $clog2(DIM)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic                    load,
  input  mm3_pkg::cmd_t           cmd,
  input  mm3_pkg::tag_t           tag_in,
  input  logic [RC_W-1:0]         row_in,
  input  logic [RC_W-1:0]         col_in,
  input  logic signed [SUM_W-1:0] sum_in,
  output mm3_pkg::tag_t           tag_out,
  output logic [RC_W-1:0]         row_out,
  output logic [RC_W-1:0]         col_out,
  output logic signed [SUM_W-1:0] sum_out
);

  // a_col[r] = A[K*DIM + r], b_row[c] = B[c*DIM + K]
  logic signed [31:0] a_col [DIM];
  logic signed [31:0] b_row [DIM];

  mm3_pkg::tag_t           tag1;
  logic [RC_W-1:0]         row1;
  logic [RC_W-1:0]         col1;
  logic signed [SUM_W-1:0] sum1;
  logic signed [63:0]      prod1;
  logic signed [63:0]      prod_next;

  assign prod_next = 64'(a_col[row_in]) * 64'(b_row[col_in]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < DIM; j++) begin
        a_col[j] <= '0;
        b_row[j] <= '0;
      end
    end else if (load) begin
      for (int j = 0; j < DIM; j++) begin
        if (cmd.op == mm3_pkg::OP_LOAD_A && int'(cmd.element_index) == K*DIM + j) begin
          a_col[j] <= cmd.element_value;
        end
        if (cmd.op == mm3_pkg::OP_LOAD_B && int'(cmd.element_index) == j*DIM + K) begin
          b_row[j] <= cmd.element_value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1    <= '0;
      tag_out <= '0;
    end else if (advance) begin
      tag1    <= tag_in;
      tag_out <= tag1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      row1    <= row_in;
      col1    <= col_in;
      sum1    <= sum_in;
      prod1   <= prod_next;
      row_out <= row1;
      col_out <= col1;
      sum_out <= sum1 + SUM_W'(prod1);
    end
  end

endmodule

// ===== hdl/matrix_multiply_3x3.sv =====
// Top level: command decode, dot-product issue, cell chain and result register.
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd): op LOAD_A or LOAD_B writes one
//   column-major element (column*DIM + row) of A or B; out-of-range indexes
//   and op code 3 are dropped. op MULTIPLY emits all DIM*DIM elements of
//   C = A*B on the prod channel in index order, the final item flagged with
//   last_result. Values are signed Q16.16; each element is the full-precision
//   sum shifted right by FRAC_BITS and saturated to 32 bits. A multiply issues
//   one dot product per cycle, except while prod_stall freezes the chain, into
//   a chain of DIM cells, two register stages per cell, and the results leave
//   one per cycle unless prod_stall holds them; the next command is taken
//   after the last result is accepted.
//   cmd_stall is high from an accepted multiply until its last item leaves.
//   Reset clears both matrices to zero and empties the chain.
//   While prod_stall holds a valid item, the whole chain freezes in place.
module matrix_multiply_3x3 #(
  parameter int DIM       = 3,
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  mm3_pkg::cmd_t  cmd,
  output logic           prod_valid,
  input  logic           prod_stall,
  output mm3_pkg::prod_t prod
);

  localparam int RC_W  = $clog2(DIM);
  localparam int SUM_W = 64 + $clog2(DIM);

  mm3_pkg::state_t state;
  mm3_pkg::state_t state_next;

  logic [RC_W-1:0] row_cnt;
  logic [RC_W-1:0] col_cnt;
  logic [3:0]      index_cnt;
  logic            issue_last;
  logic            advance;
  logic            cmd_take;
  logic            load;
  logic            start;
  mm3_pkg::tag_t   issue_tag;

  mm3_pkg::tag_t           tag_c [DIM+1];
  logic [RC_W-1:0]         row_c [DIM+1];
  logic [RC_W-1:0]         col_c [DIM+1];
  logic signed [SUM_W-1:0] sum_c [DIM+1];

  logic signed [SUM_W-1:0] shifted;
  logic [SUM_W-32:0]       top_bits;
  logic signed [31:0]      sat_value;

  assign advance    = !prod_valid || !prod_stall;
  assign cmd_stall  = (state != mm3_pkg::ST_IDLE);
  assign cmd_take   = cmd_valid && !cmd_stall;
  assign issue_last = (row_cnt == RC_W'(DIM-1)) && (col_cnt == RC_W'(DIM-1));

  always_comb begin
    load  = 1'b0;
    start = 1'b0;
    if (cmd_take) begin
      unique case (cmd.op)
        mm3_pkg::OP_LOAD_A,
        mm3_pkg::OP_LOAD_B:   load  = 1'b1;
        mm3_pkg::OP_MULTIPLY: start = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mm3_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    issue_tag       = '0;
    issue_tag.index = index_cnt;
    issue_tag.last  = issue_last;
    unique case (state)
      mm3_pkg::ST_IDLE: begin
        if (start) begin
          state_next = mm3_pkg::ST_ISSUE;
        end
      end
      mm3_pkg::ST_ISSUE: begin
        issue_tag.valid = 1'b1;
        if (advance && issue_last) begin
          state_next = mm3_pkg::ST_DRAIN;
        end
      end
      mm3_pkg::ST_DRAIN: begin
        if (prod_valid && !prod_stall && prod.last_result) begin
          state_next = mm3_pkg::ST_IDLE;
        end
      end
      default: state_next = mm3_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt   <= '0;
      col_cnt   <= '0;
      index_cnt <= '0;
    end else if (start) begin
      row_cnt   <= '0;
      col_cnt   <= '0;
      index_cnt <= '0;
    end else if (state == mm3_pkg::ST_ISSUE && advance) begin
      index_cnt <= index_cnt + 4'd1;
      if (row_cnt == RC_W'(DIM-1)) begin
        row_cnt <= '0;
        col_cnt <= col_cnt + RC_W'(1);
      end else begin
        row_cnt <= row_cnt + RC_W'(1);
      end
    end
  end

  assign tag_c[0] = issue_tag;
  assign row_c[0] = row_cnt;
  assign col_c[0] = col_cnt;
  assign sum_c[0] = '0;

  for (genvar k = 0; k < DIM; k++) begin : g_cell
    mm3_cell #(
      .DIM   (DIM),
      .K     (k),
      .SUM_W (SUM_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .load    (load),
      .cmd     (cmd),
      .tag_in  (tag_c[k]),
      .row_in  (row_c[k]),
      .col_in  (col_c[k]),
      .sum_in  (sum_c[k]),
      .tag_out (tag_c[k+1]),
      .row_out (row_c[k+1]),
      .col_out (col_c[k+1]),
      .sum_out (sum_c[k+1])
    );
  end

  // Floor shift, then clamp to the signed 32-bit range.
  assign shifted  = sum_c[DIM] >>> FRAC_BITS;
  assign top_bits = shifted[SUM_W-1:31];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      sat_value = shifted[31:0];
    end else if (top_bits[SUM_W-32]) begin
      sat_value = 32'sh8000_0000;
    end else begin
      sat_value = 32'sh7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (advance) begin
      prod_valid <= tag_c[DIM].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod.product_index <= tag_c[DIM].index;
      prod.product_value <= sat_value;
      prod.last_result   <= tag_c[DIM].last;
    end
  end

endmodule

// ===== bench/mm3_checker.sv =====
// Checker for the 3x3 matrix multiplier: mirrors both stores, predicts products, compares.
module mm3_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  logic           cmd_stall,
  input  mm3_pkg::cmd_t  cmd,
  input  logic           prod_valid,
  input  logic           prod_stall,
  input  mm3_pkg::prod_t prod,
  output int             mismatches,
  output int             awaiting,
  output int             checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAT_DIM     = 3;
  localparam int CELLS       = MAT_DIM * MAT_DIM;
  localparam int FRAC_BITS   = 16;
  localparam int MAX_REPORTS = 10;
  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  logic signed [31:0] a_cells [CELLS];
  logic signed [31:0] b_cells [CELLS];
  mm3_pkg::prod_t     expected_products [$];
  mm3_pkg::prod_t     want;

  // Full-precision dot product, floor shift, saturate to 32 bits.
  function automatic logic signed [31:0] dot_q16(int row, int col);
    logic signed [65:0] acc;
    logic signed [65:0] scaled;
    longint             term;
    acc = '0;
    for (int k = 0; k < MAT_DIM; k++) begin
      term = longint'(a_cells[k * MAT_DIM + row]) * longint'(b_cells[col * MAT_DIM + k]);
      acc += term;
    end
    scaled = acc >>> FRAC_BITS;
    if (scaled > SAT_HI) return 32'h7FFF_FFFF;
    if (scaled < SAT_LO) return 32'h8000_0000;
    return scaled[31:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CELLS; i++) begin
        a_cells[i] = '0;
        b_cells[i] = '0;
      end
      expected_products.delete();
      mismatches = 0;
      checked    = 0;
      awaiting   <= 0;
    end else begin
      if (prod_valid && !prod_stall) begin
        if (expected_products.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: unexpected product idx %0d val %h last %b",
                     $realtime, prod.product_index, prod.product_value, prod.last_result);
          mismatches++;
        end else begin
          want = expected_products.pop_front();
          checked++;
          if (prod.product_index !== want.product_index ||
              prod.product_value !== want.product_value ||
              prod.last_result !== want.last_result) begin
            if (mismatches < MAX_REPORTS)
              $display({"%0t: product mismatch, expected idx %0d val %h last %b,",
                        " got idx %0d val %h last %b"},
                       $realtime, want.product_index, want.product_value, want.last_result,
                       prod.product_index, prod.product_value, prod.last_result);
            mismatches++;
          end
        end
      end
      if (cmd_valid && !cmd_stall) begin
        case (cmd.op)
          mm3_pkg::OP_LOAD_A:
            if (cmd.element_index < CELLS) a_cells[cmd.element_index] = cmd.element_value;
          mm3_pkg::OP_LOAD_B:
            if (cmd.element_index < CELLS) b_cells[cmd.element_index] = cmd.element_value;
          mm3_pkg::OP_MULTIPLY: begin
            for (int pos = 0; pos < CELLS; pos++) begin
              want.product_index = 4'(pos);
              want.product_value = dot_q16(pos % MAT_DIM, pos / MAT_DIM);
              want.last_result   = (pos == CELLS - 1);
              expected_products.push_back(want);
            end
          end
          default: ;
        endcase
      end
      awaiting <= expected_products.size();
    end
  end

endmodule

// ===== bench/tb_matrix_multiply_3x3.sv =====
// Testbench top for the 3x3 matrix multiplier: clock, reset, stimulus and verdict.
module tb_matrix_multiply_3x3;
  timeunit 1ns;
  timeprecision 1ps;

  localparam mm3_pkg::op_t OP_UNUSED    = mm3_pkg::op_t'(2'd3);
  localparam int           CELLS        = 9;
  localparam int           TARGET_ITEMS = 370;
  localparam int           DRAIN_CYCLES = 20;

  logic           clk        = 1'b0;
  logic           rst        = 1'b1;
  logic           cmd_valid  = 1'b0;
  mm3_pkg::cmd_t  cmd        = '0;
  logic           prod_stall = 1'b0;
  logic           cmd_stall;
  logic           prod_valid;
  mm3_pkg::prod_t prod;

  int mismatches;
  int awaiting;
  int checked;

  bit quiet = 1'b0;
  int stall_hold = 0;
  int stall_roll;
  int loads_sent = 0;
  int multiplies_sent = 0;
  int ignored_sent = 0;
  int round_count = 0;

  logic [31:0] seed_a [CELLS] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                                  32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_8000,
                                  32'hFFFF_0000, 32'h1234_5678, 32'h8000_0000};
  logic [31:0] seed_b [5] = '{32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
                              32'h8000_0000, 32'h0001_0000};
  int          seed_b_idx [5] = '{0, 1, 2, 4, 8};

  matrix_multiply_3x3 uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .prod_valid(prod_valid),
    .prod_stall(prod_stall),
    .prod      (prod)
  );

  mm3_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .prod_valid(prod_valid),
    .prod_stall(prod_stall),
    .prod      (prod),
    .mismatches(mismatches),
    .awaiting  (awaiting),
    .checked   (checked)
  );

  always #1 clk = ~clk;

  // Receiver backpressure: mostly short stalls, occasional long ones.
  always @(posedge clk) begin
    if (rst || quiet) begin
      prod_stall <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      stall_roll = $urandom_range(0, 99);
      prod_stall <= (stall_roll < 35);
      if (stall_roll < 30) stall_hold = $urandom_range(0, 3);
      else if (stall_roll < 35) stall_hold = $urandom_range(10, 40);
      else stall_hold = $urandom_range(0, 6);
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] element_sample();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3, 4:    return 32'(int'($urandom_range(0, 524288)) - 262144);
      5:       return 32'(int'($urandom_range(0, 8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_cmd(mm3_pkg::op_t op, logic [3:0] idx, logic [31:0] val);
    int gap;
    cmd_valid <= 1'b1;
    cmd <= '{op: op, element_index: idx, element_value: val};
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    if (op == mm3_pkg::OP_MULTIPLY) multiplies_sent++;
    else if ((op == mm3_pkg::OP_LOAD_A || op == mm3_pkg::OP_LOAD_B) && idx < CELLS)
      loads_sent++;
    else ignored_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  initial begin
    int           n_loads;
    int           roll;
    mm3_pkg::op_t op;
    logic [3:0]   idx;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty stores, extremes, saturation both ways, ignored writes.
    send_cmd(mm3_pkg::OP_MULTIPLY, 4'd0, 32'h0);
    for (int i = 0; i < CELLS; i++) send_cmd(mm3_pkg::OP_LOAD_A, 4'(i), seed_a[i]);
    for (int i = 0; i < 5; i++) send_cmd(mm3_pkg::OP_LOAD_B, 4'(seed_b_idx[i]), seed_b[i]);
    send_cmd(mm3_pkg::OP_MULTIPLY, 4'hF, 32'hFFFF_FFFF);
    send_cmd(OP_UNUSED, 4'd3, 32'hDEAD_BEEF);
    send_cmd(mm3_pkg::OP_LOAD_A, 4'd9, 32'h5555_5555);
    send_cmd(mm3_pkg::OP_LOAD_B, 4'd15, 32'hAAAA_AAAA);
    send_cmd(mm3_pkg::OP_LOAD_A, 4'd12, 32'h7FFF_FFFF);
    send_cmd(mm3_pkg::OP_MULTIPLY, 4'd7, 32'h0);
    wait_drained();

    // Random load-and-multiply rounds with some noise mixed in.
    while (loads_sent + multiplies_sent + ignored_sent < TARGET_ITEMS) begin
      round_count++;
      quiet = (round_count % 6 == 0);
      n_loads = $urandom_range(0, 14);
      for (int i = 0; i < n_loads; i++) begin
        roll = $urandom_range(0, 99);
        op   = $urandom_range(0, 1) ? mm3_pkg::OP_LOAD_B : mm3_pkg::OP_LOAD_A;
        if (roll < 4) begin
          op  = OP_UNUSED;
          idx = 4'($urandom_range(0, 15));
        end else if (roll < 10) begin
          idx = 4'($urandom_range(9, 15));
        end else begin
          idx = 4'($urandom_range(0, CELLS - 1));
        end
        send_cmd(op, idx, element_sample());
      end
      send_cmd(mm3_pkg::OP_MULTIPLY, 4'($urandom_range(0, 15)), $urandom);
      if (round_count % 8 == 0) wait_drained();
    end

    quiet = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d element loads, %0d multiplies and %0d ignored commands",
             loads_sent, multiplies_sent, ignored_sent);
    $display("Checked %0d product elements under random sender gaps and receiver stalls",
             checked);
    if (mismatches == 0 && awaiting == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
